/* rtl/pulse_interval_varint_decoder_core_assert.svh */
// Assertion macros shared by the pulse interval decoder RTL.
`ifndef PULSE_INTERVAL_VARINT_DECODER_CORE_ASSERT_SVH
`define PULSE_INTERVAL_VARINT_DECODER_CORE_ASSERT_SVH

// Checks a property on every rising edge of clk while reset is released.
`define PIVD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds.
`define PIVD_ASSERT_NEVER(label, cond, msg) \
	`PIVD_ASSERT(label, !(cond), msg)

`endif

/* rtl/pivd_pkg.sv */
// Types and constants of the pulse interval varint decoder.
package pivd_pkg;

	localparam int COUNT_IN_BITS  = 24;
	localparam int COUNT_BITS_DEF = 24;
	localparam int TICK_BITS      = 28;
	localparam int BYTE_BITS      = 8;

	// Input mode codes.
	localparam logic MODE_BEGIN = 1'b0;
	localparam logic MODE_BYTE  = 1'b1;

	// Lead byte prefixes: mask and the value the masked byte must match.
	localparam logic [BYTE_BITS-1:0] LEAD1_MASK = 8'h80;
	localparam logic [BYTE_BITS-1:0] LEAD1_CODE = 8'h00;
	localparam logic [BYTE_BITS-1:0] LEAD2_MASK = 8'hC0;
	localparam logic [BYTE_BITS-1:0] LEAD2_CODE = 8'h80;
	localparam logic [BYTE_BITS-1:0] LEAD3_MASK = 8'hE0;
	localparam logic [BYTE_BITS-1:0] LEAD3_CODE = 8'hC0;
	localparam logic [BYTE_BITS-1:0] LEAD4_MASK = 8'hF0;
	localparam logic [BYTE_BITS-1:0] LEAD4_CODE = 8'hE0;

	// Payload bits kept from a lead byte.
	localparam logic [BYTE_BITS-1:0] LEAD2_BITS = 8'h3F;
	localparam logic [BYTE_BITS-1:0] LEAD3_BITS = 8'h1F;
	localparam logic [BYTE_BITS-1:0] LEAD4_BITS = 8'h0F;

	// Continuation bytes still to come after a lead byte.
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;
	localparam logic [1:0] PEND_THREE = 2'd3;

	localparam logic [TICK_BITS-1:0] DUMMY_TICKS = 28'd300;

	// Result queue geometry.
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = 2;
	localparam int QCNT_BITS  = 3;

	typedef struct packed {
		logic [TICK_BITS-1:0] ticks;
		logic                 last;
	} result_t;

endpackage

/* rtl/pulse_interval_varint_decoder_core.sv */
// Pulse interval varint decoder: input register, code decode and result queue.
//
//  channel  handshake            payload
//  in       in_valid / in_stall  mode, code_count, data_byte
//  out      out_valid / out_stall pulse_ticks, last
//
// One input transfer can be taken every cycle while in_stall is low; a registered
// byte is decoded once the queue has room and its results enter a four-entry
// result queue. Results leave at one per cycle while out_stall is low; the byte that
// ends a track and carries a value pushes both its value and the closing dummy.
// The input register holds while the queue has fewer than two free entries.
// Reset clears the track state and empties the queue; no clearing pass is needed.
`include "pulse_interval_varint_decoder_core_assert.svh"

module pulse_interval_varint_decoder_core #(
	parameter int COUNT_BITS = pivd_pkg::COUNT_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  mode,
	input  logic [pivd_pkg::COUNT_IN_BITS-1:0]    code_count,
	input  logic [pivd_pkg::BYTE_BITS-1:0]        data_byte,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [pivd_pkg::TICK_BITS-1:0]        pulse_ticks,
	output logic                                  last
);

	localparam int CW = (COUNT_BITS > pivd_pkg::COUNT_IN_BITS) ?
		COUNT_BITS : pivd_pkg::COUNT_IN_BITS;
	localparam int TB = pivd_pkg::TICK_BITS;
	localparam int BB = pivd_pkg::BYTE_BITS;

	// Input register.
	logic                  valid_s1;
	logic                  mode_s1;
	logic [CW-1:0]         count_s1;
	logic [BB-1:0]         byte_s1;

	// Track state.
	logic [COUNT_BITS-1:0] codes_left_q, codes_left_d;
	logic [1:0]            pend_q, pend_d;
	logic [TB-1:0]         acc_q, acc_d;
	logic                  active_q, active_d;

	// Result queue.
	pivd_pkg::result_t              q_mem_q [pivd_pkg::QDEPTH];
	logic [pivd_pkg::QPTR_BITS-1:0] q_wr_q, q_rd_q;
	logic [pivd_pkg::QCNT_BITS-1:0] q_count_q;

	logic                  in_take;
	logic                  advance;
	logic                  pop;
	logic                  finish;
	logic                  has_val;
	logic                  ends_track;
	logic [TB-1:0]         fin_val;
	logic [TB-1:0]         acc_shift;
	logic [1:0]            push_n;
	pivd_pkg::result_t     e0, e1;

	assign advance  = valid_s1 && (q_count_q <= pivd_pkg::QCNT_BITS'(2));
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1  <= mode;
			count_s1 <= CW'(code_count);
			byte_s1  <= data_byte;
		end
	end

	assign acc_shift = {acc_q[TB-BB-1:0], byte_s1};

	always_comb begin
		codes_left_d = codes_left_q;
		pend_d       = pend_q;
		acc_d        = acc_q;
		active_d     = active_q;
		finish       = 1'b0;
		has_val      = 1'b0;
		fin_val      = '0;
		ends_track   = 1'b0;
		push_n       = 2'd0;
		e0           = '0;
		e1           = '0;
		if (advance) begin
			if (mode_s1 == pivd_pkg::MODE_BEGIN) begin
				codes_left_d = count_s1[COUNT_BITS-1:0];
				active_d     = (count_s1[COUNT_BITS-1:0] != '0);
				pend_d       = pivd_pkg::PEND_NONE;
				acc_d        = '0;
			end else if (active_q) begin
				if (pend_q != pivd_pkg::PEND_NONE) begin
					acc_d  = acc_shift;
					pend_d = pend_q - 2'd1;
					if (pend_q == pivd_pkg::PEND_ONE) begin
						finish  = 1'b1;
						has_val = 1'b1;
						fin_val = acc_shift;
					end
				end else if ((byte_s1 & pivd_pkg::LEAD1_MASK) == pivd_pkg::LEAD1_CODE) begin
					finish  = 1'b1;
					has_val = 1'b1;
					fin_val = TB'(byte_s1);
				end else if ((byte_s1 & pivd_pkg::LEAD2_MASK) == pivd_pkg::LEAD2_CODE) begin
					acc_d  = TB'(byte_s1 & pivd_pkg::LEAD2_BITS);
					pend_d = pivd_pkg::PEND_ONE;
				end else if ((byte_s1 & pivd_pkg::LEAD3_MASK) == pivd_pkg::LEAD3_CODE) begin
					acc_d  = TB'(byte_s1 & pivd_pkg::LEAD3_BITS);
					pend_d = pivd_pkg::PEND_TWO;
				end else if ((byte_s1 & pivd_pkg::LEAD4_MASK) == pivd_pkg::LEAD4_CODE) begin
					acc_d  = TB'(byte_s1 & pivd_pkg::LEAD4_BITS);
					pend_d = pivd_pkg::PEND_THREE;
				end else begin
					// An invalid lead byte still uses up one code.
					finish = 1'b1;
				end
			end
			if (finish) begin
				codes_left_d = codes_left_q - COUNT_BITS'(1);
				pend_d       = pivd_pkg::PEND_NONE;
				acc_d        = '0;
				ends_track   = (codes_left_q == COUNT_BITS'(1));
				if (ends_track) begin
					active_d = 1'b0;
				end
				if (has_val) begin
					e0.ticks = fin_val;
					e0.last  = 1'b0;
					e1.ticks = pivd_pkg::DUMMY_TICKS;
					e1.last  = 1'b1;
				end else begin
					e0.ticks = pivd_pkg::DUMMY_TICKS;
					e0.last  = 1'b1;
				end
				push_n = {1'b0, has_val} + {1'b0, ends_track};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_left_q <= '0;
			pend_q       <= pivd_pkg::PEND_NONE;
			acc_q        <= '0;
			active_q     <= 1'b0;
		end else begin
			codes_left_q <= codes_left_d;
			pend_q       <= pend_d;
			acc_q        <= acc_d;
			active_q     <= active_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			q_mem_q[q_wr_q] <= e0;
		end
		if (push_n == 2'd2) begin
			q_mem_q[q_wr_q + pivd_pkg::QPTR_BITS'(1)] <= e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q    <= '0;
			q_rd_q    <= '0;
			q_count_q <= '0;
		end else begin
			q_wr_q    <= q_wr_q + pivd_pkg::QPTR_BITS'(push_n);
			q_rd_q    <= q_rd_q + pivd_pkg::QPTR_BITS'(pop);
			q_count_q <= q_count_q + pivd_pkg::QCNT_BITS'(push_n)
				- pivd_pkg::QCNT_BITS'(pop);
		end
	end

	assign out_valid   = (q_count_q != '0);
	assign pulse_ticks = q_mem_q[q_rd_q].ticks;
	assign last        = q_mem_q[q_rd_q].last;

	`PIVD_ASSERT_NEVER(a_queue_overflow, q_count_q > pivd_pkg::QCNT_BITS'(pivd_pkg::QDEPTH), "result queue overflow")
	`PIVD_ASSERT(a_active_matches_count, active_q == (codes_left_q != '0), "track flag disagrees with code count")
	`PIVD_ASSERT(a_idle_no_partial, active_q || (pend_q == pivd_pkg::PEND_NONE), "partial code held outside a track")
	`PIVD_ASSERT(a_pair_ends_track, (push_n != 2'd2) || (e1.last && !e0.last && !active_d), "two results without a track end")
	`PIVD_ASSERT(a_queue_count, q_count_q == $past(q_count_q) + pivd_pkg::QCNT_BITS'($past(push_n)) - pivd_pkg::QCNT_BITS'($past(pop)), "queue count drifted")

endmodule

/* bench/pulse_decode_checker.sv */
// Checker that predicts the decoded pulse stream from input transfers and compares results.
`timescale 1ns / 100ps
module pulse_decode_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic                               mode,
	input  logic [pivd_pkg::COUNT_IN_BITS-1:0] code_count,
	input  logic [pivd_pkg::BYTE_BITS-1:0]     data_byte,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [pivd_pkg::TICK_BITS-1:0]     pulse_ticks,
	input  logic                               last,
	output int                                 error_count,
	output int                                 pulses_outstanding,
	output int                                 pulses_checked,
	output int                                 tracks_closed
);

	logic [pivd_pkg::COUNT_BITS_DEF-1:0] codes_left;
	logic [1:0]                          bytes_pending;
	logic [pivd_pkg::TICK_BITS-1:0]      value_accum;
	logic                                track_active;
	pivd_pkg::result_t                   pulses_due[$];
	int                                  errors;
	int                                  checked;
	int                                  closed;

	// One code is complete: queue its value if it has one, then the dummy if it ends the track.
	task automatic close_code(input bit has_value,
			input logic [pivd_pkg::TICK_BITS-1:0] value);
		pivd_pkg::result_t pulse;
		if (has_value) begin
			pulse.ticks = value;
			pulse.last = 1'b0;
			pulses_due.push_back(pulse);
		end
		codes_left = codes_left - 1'b1;
		if (codes_left == '0) begin
			pulse.ticks = pivd_pkg::DUMMY_TICKS;
			pulse.last = 1'b1;
			pulses_due.push_back(pulse);
			track_active = 1'b0;
		end
		bytes_pending = pivd_pkg::PEND_NONE;
		value_accum = '0;
	endtask

	task automatic predict_pulses(input logic m,
			input logic [pivd_pkg::COUNT_IN_BITS-1:0] cnt,
			input logic [pivd_pkg::BYTE_BITS-1:0] b);
		if (m == pivd_pkg::MODE_BEGIN) begin
			codes_left = cnt[pivd_pkg::COUNT_BITS_DEF-1:0];
			track_active = (cnt[pivd_pkg::COUNT_BITS_DEF-1:0] != '0);
			bytes_pending = pivd_pkg::PEND_NONE;
			value_accum = '0;
		end else if (track_active) begin
			if (bytes_pending != pivd_pkg::PEND_NONE) begin
				value_accum = {value_accum[pivd_pkg::TICK_BITS-pivd_pkg::BYTE_BITS-1:0], b};
				bytes_pending = bytes_pending - 1'b1;
				if (bytes_pending == pivd_pkg::PEND_NONE)
					close_code(1'b1, value_accum);
			end else if ((b & pivd_pkg::LEAD1_MASK) == pivd_pkg::LEAD1_CODE) begin
				close_code(1'b1, pivd_pkg::TICK_BITS'(b));
			end else if ((b & pivd_pkg::LEAD2_MASK) == pivd_pkg::LEAD2_CODE) begin
				value_accum = pivd_pkg::TICK_BITS'(b & pivd_pkg::LEAD2_BITS);
				bytes_pending = pivd_pkg::PEND_ONE;
			end else if ((b & pivd_pkg::LEAD3_MASK) == pivd_pkg::LEAD3_CODE) begin
				value_accum = pivd_pkg::TICK_BITS'(b & pivd_pkg::LEAD3_BITS);
				bytes_pending = pivd_pkg::PEND_TWO;
			end else if ((b & pivd_pkg::LEAD4_MASK) == pivd_pkg::LEAD4_CODE) begin
				value_accum = pivd_pkg::TICK_BITS'(b & pivd_pkg::LEAD4_BITS);
				bytes_pending = pivd_pkg::PEND_THREE;
			end else begin
				// A lead byte with no prefix still uses up one code of the track.
				close_code(1'b0, '0);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pivd_pkg::result_t want;
		if (!arst_n) begin
			codes_left = '0;
			bytes_pending = pivd_pkg::PEND_NONE;
			value_accum = '0;
			track_active = 1'b0;
			pulses_due.delete();
			errors = 0;
			checked = 0;
			closed = 0;
		end else begin
			// Results at this edge come from earlier transfers, so check before predicting.
			if (out_valid && !out_stall) begin
				if (pulses_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected pulse: expected none, got ticks %0d last %b",
						$time, pulse_ticks, last);
				end else begin
					want = pulses_due.pop_front();
					checked++;
					if (want.last)
						closed++;
					if (pulse_ticks !== want.ticks) begin
						errors++;
						$display("%0t: pulse_ticks expected %0d, got %0d",
							$time, want.ticks, pulse_ticks);
					end
					if (last !== want.last) begin
						errors++;
						$display("%0t: last expected %b, got %b", $time, want.last, last);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_pulses(mode, code_count, data_byte);
		end
		error_count <= errors;
		pulses_outstanding <= pulses_due.size();
		pulses_checked <= checked;
		tracks_closed <= closed;
	end

endmodule

/* bench/testbench.sv */
// Top of the pulse interval decoder bench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

	localparam int ITEM_TARGET    = 500;
	localparam int IDLE_FREE_FROM = 420;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int CW             = pivd_pkg::COUNT_IN_BITS;
	localparam int BB             = pivd_pkg::BYTE_BITS;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic                           mode = pivd_pkg::MODE_BYTE;
	logic [CW-1:0]                  code_count = '0;
	logic [BB-1:0]                  data_byte = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [pivd_pkg::TICK_BITS-1:0] pulse_ticks;
	logic                           last;

	bit          gaps_on = 1'b1;
	bit          stalls_on = 1'b1;
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;
	int unsigned stream_items = 0;
	int          error_count;
	int          pulses_outstanding;
	int          pulses_checked;
	int          tracks_closed;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	pulse_interval_varint_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.code_count(code_count),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pulse_ticks(pulse_ticks),
		.last(last)
	);

	pulse_decode_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.code_count(code_count),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pulse_ticks(pulse_ticks),
		.last(last),
		.error_count(error_count),
		.pulses_outstanding(pulses_outstanding),
		.pulses_checked(pulses_checked),
		.tracks_closed(tracks_closed)
	);

	// Receiver back-pressure comes in bursts of random length.
	always @(negedge clk) begin
		if (!stalls_on) begin
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d pulses outstanding.",
				cycle_count, pulses_outstanding);
			$display("pulse_interval_varint_decoder_core: mismatch");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(input logic m, input logic [CW-1:0] cnt,
			input logic [BB-1:0] b);
		int unsigned gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		code_count <= cnt;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// The field that the mode leaves unused carries random bits.
	task automatic send_begin(input logic [CW-1:0] cnt);
		send_item(pivd_pkg::MODE_BEGIN, cnt, BB'($urandom));
	endtask

	task automatic send_byte(input logic [BB-1:0] b);
		send_item(pivd_pkg::MODE_BYTE, CW'($urandom), b);
	endtask

	// One whole code of random length and content; a few have no valid prefix.
	task automatic send_code();
		int unsigned pick;
		int unsigned extra;
		logic [BB-1:0] lead;
		pick = $urandom_range(0, 19);
		extra = 0;
		if (pick < 5) begin
			lead = BB'($urandom) & ~pivd_pkg::LEAD1_MASK;
		end else if (pick < 10) begin
			lead = pivd_pkg::LEAD2_CODE | (BB'($urandom) & pivd_pkg::LEAD2_BITS);
			extra = 1;
		end else if (pick < 14) begin
			lead = pivd_pkg::LEAD3_CODE | (BB'($urandom) & pivd_pkg::LEAD3_BITS);
			extra = 2;
		end else if (pick < 18) begin
			lead = pivd_pkg::LEAD4_CODE | (BB'($urandom) & pivd_pkg::LEAD4_BITS);
			extra = 3;
		end else begin
			lead = pivd_pkg::LEAD4_MASK | (BB'($urandom) & pivd_pkg::LEAD4_BITS);
		end
		send_byte(lead);
		repeat (extra) send_byte(BB'($urandom));
		stream_items += extra + 1;
	endtask

	initial begin
		int unsigned track_len;
		logic [CW-1:0] cnt;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Bytes before any track and after a zero count must be dropped.
		send_byte(8'h05);
		send_begin('0);
		send_byte(8'h11);
		// Smallest and largest one-byte value, the largest of each longer code, then a bad lead ending the track.
		send_begin(CW'(6));
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(8'hBF);
		send_byte(8'hFF);
		send_byte(8'hDF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hEF);
		repeat (3) send_byte(8'hFF);
		send_byte(8'hF5);
		send_byte(8'h80);
		// A new track while a long code is half gathered throws that code away.
		send_begin(CW'(3));
		send_byte(8'hE1);
		send_byte(8'h12);
		send_begin(CW'(1));
		send_byte(8'h80);
		send_byte(8'h01);
		send_begin('1);
		send_byte(8'h2A);

		while (stream_items < ITEM_TARGET) begin
			gaps_on = (stream_items < IDLE_FREE_FROM) && ($urandom_range(0, 3) != 0);
			stalls_on <= (stream_items < IDLE_FREE_FROM) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 19))
				0: cnt = CW'($urandom);
				1: cnt = '0;
				default: cnt = CW'($urandom_range(1, 8));
			endcase
			send_begin(cnt);
			stream_items++;
			track_len = (cnt > 8) ? $urandom_range(1, 12) : 32'(cnt);
			if (track_len > 1 && $urandom_range(0, 7) == 0) begin
				// Cut the track short and leave a long code open for the next begin to drop.
				track_len = $urandom_range(0, track_len - 1);
				repeat (track_len) send_code();
				send_byte(pivd_pkg::LEAD3_CODE | (BB'($urandom) & pivd_pkg::LEAD3_BITS));
			end else begin
				repeat (track_len) send_code();
			end
			if ($urandom_range(0, 4) == 0)
				send_byte(BB'($urandom));
		end
		in_valid <= 1'b0;

		while (pulses_outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Drove %0d stream items after the directed codes; %0d pulses compared.",
			stream_items, pulses_checked);
		$display("%0d tracks ended with the dummy pulse; %0d errors found.",
			tracks_closed, error_count);
		if (error_count == 0)
			$display("pulse_interval_varint_decoder_core: match");
		else
			$display("pulse_interval_varint_decoder_core: mismatch");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/pivd_pkg.sv
rtl/pulse_interval_varint_decoder_core.sv
bench/pulse_decode_checker.sv
bench/testbench.sv
